// File: rtl/ook_pulse_qualifier_assert.svh
// Assertion helpers shared by the block. Both expect clk and arst_n in scope.
`ifndef OOK_PULSE_QUALIFIER_ASSERT_SVH
`define OOK_PULSE_QUALIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OPQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/opq_pkg.sv
package opq_pkg;

	// Default sizing of the qualifier.
	localparam int WARMUP_SEGMENTS_DEF = 8;
	localparam int MAX_RECORDS_DEF     = 4096;

	// Record positions whose strengths feed the reference averages.
	localparam int CAP_FIRST = 5;
	localparam int CAP_LAST  = 8;

	// Front-end operation codes.
	localparam logic [1:0] OP_HIGH_END   = 2'd0;
	localparam logic [1:0] OP_LOW_END    = 2'd1;
	localparam logic [1:0] OP_LONG_PAUSE = 2'd2;
	localparam logic [1:0] OP_FAULT      = 2'd3;

	// End codes.
	localparam logic [3:0] END_PAUSE          = 4'd0;
	localparam logic [3:0] END_LIMIT          = 4'd1;
	localparam logic [3:0] END_WEAK_START     = 4'd2;
	localparam logic [3:0] END_STRONG_START   = 4'd3;
	localparam logic [3:0] END_WARMUP_PAUSE   = 4'd4;
	localparam logic [3:0] END_WARMUP_UNREL_H = 4'd5;
	localparam logic [3:0] END_WARMUP_UNREL_L = 4'd6;
	localparam logic [3:0] END_FEW_REL_H      = 4'd7;
	localparam logic [3:0] END_FEW_REL_L      = 4'd8;
	localparam logic [3:0] END_MANY_UNREL_H   = 4'd9;
	localparam logic [3:0] END_MANY_UNREL_L   = 4'd10;
	localparam logic [3:0] END_COLLISION      = 4'd11;
	localparam logic [3:0] END_FAULT          = 4'd12;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELTA       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd2;
	localparam int CFG_DATA_W = 12;

	localparam logic [7:0]  SENSITIVITY_RST = 8'd40;
	localparam logic [7:0]  DELTA_RST       = 8'd8;
	localparam logic [11:0] MAX_LENGTH_RST  = 12'd4095;

	// Saturation points of the run and unreliable counters.
	localparam logic [1:0]  RUN_MAX = 2'd3;
	localparam logic [11:0] CNT_MAX = 12'd4095;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] duration;
		logic [7:0]  next_strength;
	} item_t;

	typedef struct packed {
		logic [7:0]  sensitivity;
		logic [7:0]  delta_strength;
		logic [11:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic        record_valid;
		logic [11:0] record_index;
		logic [30:0] record_value;
		logic        finished;
		logic [3:0]  end_code;
		logic [11:0] recorded_count;
		logic [11:0] unreliable_total;
		logic [7:0]  ref_high;
		logic [7:0]  ref_low;
	} res_t;

endpackage

// File: rtl/opq_in_stage.sv
module opq_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  opq_pkg::item_t in_item,
	input  logic          advance,
	output logic          s1_valid,
	output opq_pkg::item_t s1_item
);

	logic           valid_s1;
	opq_pkg::item_t item_s1;
	logic           accept;

	// The stage can refill in the same cycle in which its item moves on.
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

endmodule

// File: rtl/opq_core.sv
module opq_core #(
	parameter int WARMUP_SEGMENTS = opq_pkg::WARMUP_SEGMENTS_DEF,
	parameter int MAX_RECORDS     = opq_pkg::MAX_RECORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  opq_pkg::item_t item,
	input  opq_pkg::cfg_t  cfg,
	output opq_pkg::res_t  res,
	output logic           res_any
);

	// Position counter covers the limit plus the warm-up overshoot.
	localparam int PW = $clog2(MAX_RECORDS + WARMUP_SEGMENTS + 4);
	localparam logic [PW-1:0] REC_LAST = PW'(MAX_RECORDS - 1);
	localparam logic [PW-1:0] WARM_CNT = PW'(WARMUP_SEGMENTS);
	localparam logic [PW-1:0] POS_ONE  = PW'(1);

	typedef enum logic [2:0] {
		PH_WAIT_PAUSE,
		PH_WAIT_START,
		PH_WARM_HIGH,
		PH_WARM_LOW,
		PH_MAIN_HIGH,
		PH_MAIN_LOW
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d, pos_inc, limit;
	logic [11:0] kept_q, kept_d;
	logic [1:0]  rel_q, rel_d, rel_inc;
	logic [1:0]  ur_q, ur_d;
	logic [1:0]  cr_q, cr_d;
	logic [7:0]  ws_q [4];
	logic [7:0]  ws_d [4];
	logic [7:0]  cur_q, cur_d;
	logic [7:0]  plow_q, plow_d;
	logic [11:0] cnt_q, cnt_d, cnt_inc;
	logic [7:0]  refh_q, refh_d;
	logic [7:0]  refl_q, refl_d;

	logic [7:0]  refh_o, refl_o;
	logic        rec_vld, rec_ok, fin;
	logic [3:0]  code;
	logic [8:0]  sens_hi, low_step, ns_step, win_up;
	logic [7:0]  win_lo;
	logic        hi_ge_low, hi_ge_ns, ns_ge_low, out_win;
	logic        cap_hit, lim_over, warm;
	logic [1:0]  cap_idx;
	logic [8:0]  sum_h, sum_l;

	always_comb begin
		sens_hi   = {1'b0, cfg.sensitivity} + {2'b0, cfg.sensitivity[7:1]};
		low_step  = {1'b0, plow_q} + {1'b0, cfg.delta_strength};
		ns_step   = {1'b0, item.next_strength} + {1'b0, cfg.delta_strength};
		hi_ge_low = {1'b0, cur_q} >= low_step;
		hi_ge_ns  = {1'b0, cur_q} >= ns_step;
		ns_ge_low = {1'b0, item.next_strength} >= low_step;
		win_up    = {1'b0, refh_q} + {1'b0, cfg.delta_strength};
		win_lo    = (refh_q > cfg.delta_strength) ? (refh_q - cfg.delta_strength) : 8'd0;
		out_win   = ({1'b0, cur_q} > win_up) || (cur_q < win_lo);
		pos_inc   = pos_q + POS_ONE;
		lim_over  = {20'd0, cfg.max_length} > 32'(MAX_RECORDS - 1);
		limit     = lim_over ? REC_LAST : PW'(cfg.max_length);
		cap_hit   = (pos_q >= PW'(opq_pkg::CAP_FIRST)) && (pos_q <= PW'(opq_pkg::CAP_LAST));
		cap_idx   = 2'(pos_q - PW'(opq_pkg::CAP_FIRST));
		rel_inc   = (rel_q == opq_pkg::RUN_MAX) ? opq_pkg::RUN_MAX : rel_q + 2'd1;
		cnt_inc   = (cnt_q == opq_pkg::CNT_MAX) ? cnt_q : cnt_q + 12'd1;
		warm      = (phase_q == PH_WARM_HIGH) || (phase_q == PH_WARM_LOW);
	end

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		kept_d  = kept_q;
		rel_d   = rel_q;
		ur_d    = ur_q;
		cr_d    = cr_q;
		ws_d    = ws_q;
		cur_d   = cur_q;
		plow_d  = plow_q;
		cnt_d   = cnt_q;
		refh_d  = refh_q;
		refl_d  = refl_q;
		refh_o  = refh_q;
		refl_o  = refl_q;
		rec_vld = 1'b0;
		rec_ok  = 1'b0;
		fin     = 1'b0;
		code    = opq_pkg::END_PAUSE;

		case (phase_q)
			PH_WAIT_START: begin
				if (item.operation == opq_pkg::OP_LOW_END) begin
					refh_o = item.next_strength;
					refl_o = 8'd0;
					if (item.next_strength < cfg.sensitivity) begin
						fin  = 1'b1;
						code = opq_pkg::END_WEAK_START;
					end else if ({1'b0, item.next_strength} > sens_hi) begin
						fin  = 1'b1;
						code = opq_pkg::END_STRONG_START;
					end else begin
						phase_d = PH_WARM_HIGH;
						cur_d   = item.next_strength;
						plow_d  = 8'd0;
						pos_d   = POS_ONE;
						refh_d  = 8'd0;
						refl_d  = 8'd0;
					end
				end
			end
			PH_WARM_HIGH, PH_MAIN_HIGH: begin
				if (cap_hit) ws_d[cap_idx] = cur_q;
				rec_vld = 1'b1;
				pos_d   = pos_inc;
				if (item.operation != opq_pkg::OP_HIGH_END) begin
					fin  = 1'b1;
					code = opq_pkg::END_FAULT;
				end else begin
					plow_d = item.next_strength;
					rec_ok = hi_ge_low && hi_ge_ns;
					if (warm) begin
						if (!rec_ok) begin
							fin  = 1'b1;
							code = opq_pkg::END_WARMUP_UNREL_H;
						end else begin
							phase_d = PH_WARM_LOW;
						end
					end else begin
						phase_d = PH_MAIN_LOW;
						if (rec_ok) begin
							rel_d = rel_inc;
							ur_d  = 2'd0;
							if (out_win) begin
								if (cr_q == opq_pkg::RUN_MAX) begin
									fin  = 1'b1;
									code = opq_pkg::END_COLLISION;
								end else begin
									cr_d = cr_q + 2'd1;
								end
							end else begin
								cr_d = 2'd0;
							end
						end else begin
							cnt_d = cnt_inc;
							if (ur_q == 2'd0 && rel_q != opq_pkg::RUN_MAX) begin
								fin  = 1'b1;
								code = opq_pkg::END_FEW_REL_H;
							end else if (ur_q == opq_pkg::RUN_MAX) begin
								fin  = 1'b1;
								code = opq_pkg::END_MANY_UNREL_H;
							end else begin
								rel_d = 2'd0;
								ur_d  = ur_q + 2'd1;
							end
						end
					end
				end
			end
			PH_WARM_LOW, PH_MAIN_LOW: begin
				if (cap_hit) ws_d[cap_idx] = plow_q;
				rec_vld = 1'b1;
				pos_d   = pos_inc;
				if (item.operation == opq_pkg::OP_LONG_PAUSE) begin
					rec_ok = 1'b1;
					kept_d = 12'(pos_q - POS_ONE);
					fin    = 1'b1;
					code   = warm ? opq_pkg::END_WARMUP_PAUSE : opq_pkg::END_PAUSE;
				end else if (item.operation != opq_pkg::OP_LOW_END) begin
					if (warm) kept_d = 12'(pos_q - POS_ONE);
					fin  = 1'b1;
					code = opq_pkg::END_FAULT;
				end else begin
					cur_d  = item.next_strength;
					rec_ok = hi_ge_low && ns_ge_low;
					if (warm) begin
						if (!rec_ok) begin
							fin  = 1'b1;
							code = opq_pkg::END_WARMUP_UNREL_L;
						end else if (pos_inc > WARM_CNT) begin
							cr_d    = 2'd0;
							ur_d    = 2'd0;
							rel_d   = opq_pkg::RUN_MAX;
							refh_d  = sum_h[8:1];
							refl_d  = sum_l[8:1];
							phase_d = PH_MAIN_HIGH;
						end else begin
							phase_d = PH_WARM_HIGH;
						end
					end else begin
						if (rec_ok) begin
							kept_d = 12'(pos_inc);
							rel_d  = rel_inc;
							ur_d   = 2'd0;
						end else begin
							cnt_d = cnt_inc;
							if (ur_q == 2'd0 && rel_q != opq_pkg::RUN_MAX) begin
								fin  = 1'b1;
								code = opq_pkg::END_FEW_REL_L;
							end else if (ur_q == opq_pkg::RUN_MAX) begin
								fin  = 1'b1;
								code = opq_pkg::END_MANY_UNREL_L;
							end else begin
								rel_d = 2'd0;
								ur_d  = ur_q + 2'd1;
							end
						end
						if (!fin) begin
							if (pos_inc >= limit) begin
								kept_d = 12'(pos_inc);
								fin    = 1'b1;
								code   = opq_pkg::END_LIMIT;
							end else begin
								phase_d = PH_MAIN_HIGH;
							end
						end
					end
				end
			end
			default: begin
				phase_d = (item.operation == opq_pkg::OP_LONG_PAUSE) ? PH_WAIT_START : PH_WAIT_PAUSE;
			end
		endcase
	end

	// References average the strengths captured so far, including this beat's.
	assign sum_h = {1'b0, ws_d[0]} + {1'b0, ws_d[2]};
	assign sum_l = {1'b0, ws_d[1]} + {1'b0, ws_d[3]};

	always_comb begin
		res.record_valid     = rec_vld;
		res.record_index     = rec_vld ? 12'(pos_q) : 12'd0;
		res.record_value     = rec_vld ? {item.duration[31:2], !rec_ok} : 31'd0;
		res.finished         = fin;
		res.end_code         = fin ? code : 4'd0;
		res.recorded_count   = fin ? kept_d - 12'd1 : 12'd0;
		res.unreliable_total = fin ? cnt_d : 12'd0;
		res.ref_high         = fin ? refh_o : 8'd0;
		res.ref_low          = fin ? refl_o : 8'd0;
		res_any              = rec_vld || fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_PAUSE;
			pos_q   <= POS_ONE;
			kept_q  <= 12'd1;
			rel_q   <= 2'd0;
			ur_q    <= 2'd0;
			cr_q    <= 2'd0;
			for (int i = 0; i < 4; i++) ws_q[i] <= 8'd0;
			cur_q   <= 8'd0;
			plow_q  <= 8'd0;
			cnt_q   <= 12'd0;
			refh_q  <= 8'd0;
			refl_q  <= 8'd0;
		end else if (step && fin) begin
			// Every end of reception starts over from the waiting state.
			phase_q <= PH_WAIT_PAUSE;
			pos_q   <= POS_ONE;
			kept_q  <= 12'd1;
			rel_q   <= 2'd0;
			ur_q    <= 2'd0;
			cr_q    <= 2'd0;
			for (int i = 0; i < 4; i++) ws_q[i] <= 8'd0;
			cur_q   <= 8'd0;
			plow_q  <= 8'd0;
			cnt_q   <= 12'd0;
			refh_q  <= 8'd0;
			refl_q  <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			kept_q  <= kept_d;
			rel_q   <= rel_d;
			ur_q    <= ur_d;
			cr_q    <= cr_d;
			ws_q    <= ws_d;
			cur_q   <= cur_d;
			plow_q  <= plow_d;
			cnt_q   <= cnt_d;
			refh_q  <= refh_d;
			refl_q  <= refl_d;
		end
	end

endmodule

// File: rtl/opq_out_stage.sv
module opq_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          res_any,
	input  opq_pkg::res_t res_in,
	output logic          take,
	output logic          out_valid,
	input  logic          out_stall,
	output opq_pkg::res_t res_out
);

	logic          valid_q;
	opq_pkg::res_t res_q;

	// Room for a new result when empty or when the held one leaves now.
	assign take = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_any;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_any) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

// File: rtl/ook_pulse_qualifier.sv
// A segment beat goes from the input register via the core into the output register.
// Throughput: one beat per cycle unless the output stalls; single-pass state update.
// A beat that causes no result is consumed without occupying the output register.
// Reset: arst_n clears the qualifier to waiting for a long pause and the registers
// to their defaults (sensitivity 40, delta 8, max length 4095); no clearing pass.
`include "ook_pulse_qualifier_assert.svh"

module ook_pulse_qualifier #(
	parameter int WARMUP_SEGMENTS = opq_pkg::WARMUP_SEGMENTS_DEF,
	parameter int MAX_RECORDS     = opq_pkg::MAX_RECORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Segment channel from the front end.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [31:0]                   duration,
	input  logic [7:0]                    next_strength,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          record_valid,
	output logic [11:0]                   record_index,
	output logic [30:0]                   record_value,
	output logic                          finished,
	output logic [3:0]                    end_code,
	output logic [11:0]                   recorded_count,
	output logic [11:0]                   unreliable_total,
	output logic [7:0]                    ref_high,
	output logic [7:0]                    ref_low,
	// Register write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [opq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [opq_pkg::CFG_DATA_W-1:0] cfg_data
);

	opq_pkg::item_t in_item;
	opq_pkg::item_t s1_item;
	opq_pkg::cfg_t  cfg_q;
	opq_pkg::res_t  core_res;
	opq_pkg::res_t  out_res;
	logic           s1_valid;
	logic           take;
	logic           advance;
	logic           core_any;

	assign in_item.operation     = operation;
	assign in_item.duration      = duration;
	assign in_item.next_strength = next_strength;

	// Registers are always writable. Writes are expected only while the block is
	// idle, so the qualifier never sees a setting change in the middle of a beat.
	// An index beyond the three registers is accepted and has no effect.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensitivity    <= opq_pkg::SENSITIVITY_RST;
			cfg_q.delta_strength <= opq_pkg::DELTA_RST;
			cfg_q.max_length     <= opq_pkg::MAX_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				opq_pkg::CFG_SENSITIVITY: cfg_q.sensitivity    <= cfg_data[7:0];
				opq_pkg::CFG_DELTA:       cfg_q.delta_strength <= cfg_data[7:0];
				opq_pkg::CFG_MAX_LENGTH:  cfg_q.max_length     <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// The beat in the input register is processed in the cycle in which the
	// output register can take its result. A beat without a result still needs
	// that slot so that results leave in the same order as the beats came in.
	assign advance = s1_valid && take;

	opq_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.s1_valid (s1_valid),
		.s1_item  (s1_item)
	);

	// Phase tracking, reliability checks, run counters and reference averaging
	// all sit in one combinational pass on the registered beat.
	opq_core #(
		.WARMUP_SEGMENTS (WARMUP_SEGMENTS),
		.MAX_RECORDS     (MAX_RECORDS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (s1_item),
		.cfg     (cfg_q),
		.res     (core_res),
		.res_any (core_any)
	);

	opq_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res_any   (core_any),
		.res_in    (core_res),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (out_res)
	);

	assign record_valid     = out_res.record_valid;
	assign record_index     = out_res.record_index;
	assign record_value     = out_res.record_value;
	assign finished         = out_res.finished;
	assign end_code         = out_res.end_code;
	assign recorded_count   = out_res.recorded_count;
	assign unreliable_total = out_res.unreliable_total;
	assign ref_high         = out_res.ref_high;
	assign ref_low          = out_res.ref_low;

	// A result beat always carries a record, an end of reception, or both.
	`OPQ_ASSERT_SAME(a_result_has_content, out_valid, record_valid || finished, "empty result beat")

	// A rejected start pulse ends reception without writing a record.
	`OPQ_ASSERT_SAME(a_start_reject_no_record, out_valid && finished && (end_code == opq_pkg::END_WEAK_START || end_code == opq_pkg::END_STRONG_START), !record_valid, "record on rejected start")

	// While the input is stalled the held beat must still be there next cycle.
	`OPQ_ASSERT_NEXT(a_stall_keeps_beat, in_stall, s1_valid, "stalled beat lost")

endmodule

// File: tb/tb_top.sv
module tb_top;
	import opq_pkg::*;

	// Where the qualifier stands in a reception. These mirror the block's own
	// sequencing: wait for a long pause, wait for the start pulse, then the
	// warm-up highs and lows, then the main highs and lows.
	typedef enum logic [2:0] {
		Q_WAIT_PAUSE,
		Q_WAIT_START,
		Q_WARM_HIGH,
		Q_WARM_LOW,
		Q_MAIN_HIGH,
		Q_MAIN_LOW
	} qual_state_e;

	// One row of the directed table. When known is set, the result is typed in
	// by hand; otherwise the predictor decides what the row produces.
	typedef struct {
		item_t seg;
		bit    known;
		res_t  exp;
	} dir_row_t;

	// Travels alongside every offered segment so that the acceptance monitor
	// knows whether a hand-written result replaces the predicted one.
	typedef struct {
		bit   known;
		res_t exp;
	} seg_tag_t;

	localparam int RX_HOLD_CYCLES = 400;
	localparam int RESULTS_PER_PHASE = 200;
	localparam int SETTLE_CYCLES = 6;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [31:0] duration;
	logic [7:0]  next_strength;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        record_valid;
	logic [11:0] record_index;
	logic [30:0] record_value;
	logic        finished;
	logic [3:0]  end_code;
	logic [11:0] recorded_count;
	logic [11:0] unreliable_total;
	logic [7:0]  ref_high;
	logic [7:0]  ref_low;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ook_pulse_qualifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.duration(duration),
		.next_strength(next_strength),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.record_valid(record_valid),
		.record_index(record_index),
		.record_value(record_value),
		.finished(finished),
		.end_code(end_code),
		.recorded_count(recorded_count),
		.unreliable_total(unreliable_total),
		.ref_high(ref_high),
		.ref_low(ref_low),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 20 time unit period, starting low.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Scoreboard storage and run bookkeeping.
	res_t     expected_results[$];
	seg_tag_t seg_tags[$];
	dir_row_t dir_rows[$];
	int       errors = 0;
	int       phase_results = 0;
	int       hold_left = 0;
	int       tx_idle_pct = 0;
	int       rx_idle_pct = 0;

	// Our copy of the register file, as last written.
	int unsigned c_sens;
	int unsigned c_delta;
	int unsigned c_max_length;

	// Our copy of the qualifier state.
	qual_state_e q_state;
	int unsigned q_pos;
	int unsigned q_kept;
	int unsigned q_rel_run;
	int unsigned q_unrel_run;
	int unsigned q_coll_run;
	int unsigned q_warm [4];
	int unsigned q_cur_str;
	int unsigned q_prev_low;
	int unsigned q_unrel_cnt;
	int unsigned q_ref_hi;
	int unsigned q_ref_lo;

	// Every end of reception drops back to waiting for a long pause with all
	// bookkeeping cleared.
	function automatic void clear_reception();
		q_state = Q_WAIT_PAUSE;
		q_pos = 1;
		q_kept = 1;
		q_rel_run = 0;
		q_unrel_run = 0;
		q_coll_run = 0;
		for (int k = 0; k < 4; k++)
			q_warm[k] = 0;
		q_cur_str = 0;
		q_prev_low = 0;
		q_unrel_cnt = 0;
		q_ref_hi = 0;
		q_ref_lo = 0;
	endfunction

	// A record carries half the duration; bit 0 flags an unreliable segment.
	function automatic void emit_record(inout res_t r, input bit reliable,
			input logic [31:0] dur);
		logic [31:0] v;
		v = dur >> 1;
		v = reliable ? (v & ~32'd1) : (v | 32'd1);
		r.record_valid = 1'b1;
		r.record_index = q_pos[11:0];
		r.record_value = v[30:0];
		q_pos++;
	endfunction

	function automatic void close_reception(inout res_t r, input logic [3:0] code);
		r.finished = 1'b1;
		r.end_code = code;
		r.recorded_count = (q_kept - 1) & 12'hFFF;
		r.unreliable_total = q_unrel_cnt[11:0];
		r.ref_high = q_ref_hi[7:0];
		r.ref_low = q_ref_lo[7:0];
		clear_reception();
	endfunction

	function automatic void count_unreliable();
		if (q_unrel_cnt < 4095)
			q_unrel_cnt++;
	endfunction

	// Works out what one accepted segment does to the qualifier. Returns 1 when
	// the segment produces a result beat, with that beat in r.
	function automatic bit qualify_segment(input item_t seg, output res_t r);
		int unsigned ns;
		int unsigned pos;
		int unsigned hi;
		int unsigned oldlow;
		int unsigned limit;
		int unsigned up;
		int unsigned lo;
		bit ok;
		r = '0;
		ns = seg.next_strength;
		pos = q_pos;
		hi = q_cur_str;
		oldlow = q_prev_low;
		limit = (c_max_length > MAX_RECORDS_DEF - 1) ? MAX_RECORDS_DEF - 1 : c_max_length;
		case (q_state)
		Q_WAIT_START: begin
			// Only a low that ends carries the start pulse strength.
			if (seg.operation != OP_LOW_END)
				return 1'b0;
			q_ref_hi = ns;
			q_ref_lo = 0;
			if (ns < c_sens) begin
				close_reception(r, END_WEAK_START);
				return 1'b1;
			end
			if (ns > c_sens + (c_sens >> 1)) begin
				close_reception(r, END_STRONG_START);
				return 1'b1;
			end
			q_ref_hi = 0;
			q_cur_str = ns;
			q_prev_low = 0;
			q_pos = 1;
			q_state = Q_WARM_HIGH;
			return 1'b0;
		end
		Q_WARM_HIGH, Q_MAIN_HIGH: begin
			if (pos >= CAP_FIRST && pos <= CAP_LAST)
				q_warm[(pos - CAP_FIRST) & 3] = hi;
			if (seg.operation != OP_HIGH_END) begin
				emit_record(r, 1'b0, seg.duration);
				close_reception(r, END_FAULT);
				return 1'b1;
			end
			q_prev_low = ns;
			ok = (hi >= oldlow + c_delta) && (hi >= ns + c_delta);
			emit_record(r, ok, seg.duration);
			if (q_state == Q_WARM_HIGH) begin
				if (!ok) begin
					close_reception(r, END_WARMUP_UNREL_H);
					return 1'b1;
				end
				q_state = Q_WARM_LOW;
				return 1'b1;
			end
			if (ok) begin
				// The collision window saturates at zero at its lower end only.
				up = q_ref_hi + c_delta;
				lo = (q_ref_hi > c_delta) ? q_ref_hi - c_delta : 0;
				if (q_rel_run < 3)
					q_rel_run++;
				q_unrel_run = 0;
				if (hi > up || hi < lo) begin
					q_coll_run++;
					if (q_coll_run > 3) begin
						close_reception(r, END_COLLISION);
						return 1'b1;
					end
				end else begin
					q_coll_run = 0;
				end
			end else begin
				count_unreliable();
				if (q_unrel_run == 0 && q_rel_run < 3) begin
					close_reception(r, END_FEW_REL_H);
					return 1'b1;
				end
				q_rel_run = 0;
				q_unrel_run++;
				if (q_unrel_run > 3) begin
					close_reception(r, END_MANY_UNREL_H);
					return 1'b1;
				end
			end
			q_state = Q_MAIN_LOW;
			return 1'b1;
		end
		Q_WARM_LOW, Q_MAIN_LOW: begin
			if (pos >= CAP_FIRST && pos <= CAP_LAST)
				q_warm[(pos - CAP_FIRST) & 3] = oldlow;
			if (seg.operation == OP_LONG_PAUSE) begin
				emit_record(r, 1'b1, seg.duration);
				q_kept = (pos - 1) & 12'hFFF;
				close_reception(r, (q_state == Q_WARM_LOW) ? END_WARMUP_PAUSE : END_PAUSE);
				return 1'b1;
			end
			if (seg.operation != OP_LOW_END) begin
				emit_record(r, 1'b0, seg.duration);
				if (q_state == Q_WARM_LOW)
					q_kept = (pos - 1) & 12'hFFF;
				close_reception(r, END_FAULT);
				return 1'b1;
			end
			q_cur_str = ns;
			ok = (hi >= oldlow + c_delta) && (ns >= oldlow + c_delta);
			emit_record(r, ok, seg.duration);
			if (q_state == Q_WARM_LOW) begin
				if (!ok) begin
					close_reception(r, END_WARMUP_UNREL_L);
					return 1'b1;
				end
				if (q_pos > WARMUP_SEGMENTS_DEF) begin
					// Warm-up done: references come from captured positions 5 to 8.
					q_coll_run = 0;
					q_unrel_run = 0;
					q_rel_run = 3;
					q_ref_hi = (q_warm[0] + q_warm[2]) >> 1;
					q_ref_lo = (q_warm[1] + q_warm[3]) >> 1;
					q_state = Q_MAIN_HIGH;
				end else begin
					q_state = Q_WARM_HIGH;
				end
				return 1'b1;
			end
			if (ok) begin
				q_kept = q_pos & 12'hFFF;
				if (q_rel_run < 3)
					q_rel_run++;
				q_unrel_run = 0;
			end else begin
				count_unreliable();
				if (q_unrel_run == 0 && q_rel_run < 3) begin
					close_reception(r, END_FEW_REL_L);
					return 1'b1;
				end
				q_rel_run = 0;
				q_unrel_run++;
				if (q_unrel_run > 3) begin
					close_reception(r, END_MANY_UNREL_L);
					return 1'b1;
				end
			end
			if (q_pos >= limit) begin
				q_kept = q_pos & 12'hFFF;
				close_reception(r, END_LIMIT);
				return 1'b1;
			end
			q_state = Q_MAIN_HIGH;
			return 1'b1;
		end
		default: begin
			// Waiting for a long pause: only the pause itself moves us on.
			q_state = (seg.operation == OP_LONG_PAUSE) ? Q_WAIT_START : Q_WAIT_PAUSE;
			return 1'b0;
		end
		endcase
		return 1'b0;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	task automatic compare_result(input res_t want, input res_t got);
		compare_field("record_valid", want.record_valid, got.record_valid);
		compare_field("record_index", want.record_index, got.record_index);
		compare_field("record_value", want.record_value, got.record_value);
		compare_field("finished", want.finished, got.finished);
		compare_field("end_code", want.end_code, got.end_code);
		compare_field("recorded_count", want.recorded_count, got.recorded_count);
		compare_field("unreliable_total", want.unreliable_total, got.unreliable_total);
		compare_field("ref_high", want.ref_high, got.ref_high);
		compare_field("ref_low", want.ref_low, got.ref_low);
	endtask

	// Both channels are observed on the rising edge, before the block's own
	// registers move. Output beats are checked first, then the accepted
	// segment is run through the predictor; as every segment passes the input and
	// output registers, a result never belongs to the segment accepted at that edge.
	always @(posedge clk) begin : beat_monitor
		res_t        got;
		res_t        pred;
		item_t       seg;
		seg_tag_t    tag;
		bit          has;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.record_valid = record_valid;
				got.record_index = record_index;
				got.record_value = record_value;
				got.finished = finished;
				got.end_code = end_code;
				got.recorded_count = recorded_count;
				got.unreliable_total = unreliable_total;
				got.ref_high = ref_high;
				got.ref_low = ref_low;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, got %0h", $time, got);
				end else begin
					compare_result(expected_results.pop_front(), got);
				end
			end
			if (in_valid && !in_stall) begin
				seg.operation = operation;
				seg.duration = duration;
				seg.next_strength = next_strength;
				has = qualify_segment(seg, pred);
				tag = seg_tags.pop_front();
				if (tag.known) begin
					expected_results.push_back(tag.exp);
					phase_results++;
				end else if (has) begin
					expected_results.push_back(pred);
					phase_results++;
				end
			end
		end
	end

	// Receiver side. A long hold-off, once requested, is counted down here one
	// cycle at a time; otherwise the receiver stalls at the current rate.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Offers one segment beat. Called at a falling edge and returns at the
	// falling edge after acceptance, leaving in_valid high so that a following
	// beat can be offered back to back.
	task automatic send_segment(input logic [1:0] op, input logic [31:0] dur,
			input logic [7:0] ns, input bit known, input res_t exp);
		seg_tag_t tag;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		tag.known = known;
		tag.exp = exp;
		seg_tags.push_back(tag);
		in_valid <= 1'b1;
		operation <= op;
		duration <= dur;
		next_strength <= ns;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_rand(input logic [1:0] op, input logic [31:0] dur,
			input logic [7:0] ns);
		send_segment(op, dur, ns, 1'b0, '0);
	endtask

	// Leaves cfg_valid high so that several writes can follow each other.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
		CFG_SENSITIVITY: c_sens = data[7:0];
		CFG_DELTA:       c_delta = data[7:0];
		CFG_MAX_LENGTH:  c_max_length = data[11:0];
		default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic write_regs(input int unsigned sens, input int unsigned delta,
			input int unsigned max_len);
		write_reg(CFG_SENSITIVITY, sens);
		write_reg(CFG_DELTA, delta);
		write_reg(CFG_MAX_LENGTH, max_len);
		cfg_valid <= 1'b0;
	endtask

	// Stops offering and waits until every expected beat has come back, then
	// waits SETTLE_CYCLES longer so that segments with no result can settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_duration();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 32'd0;
		if (pick == 1)
			return 32'hFFFF_FFFF;
		if (pick < 6)
			return $urandom;
		return $urandom_range(1, 5000);
	endfunction

	function automatic logic [7:0] clip_strength(input int unsigned s);
		return (s > 255) ? 8'd255 : s[7:0];
	endfunction

	// Strength for a high: mostly nominal, sometimes above the collision window,
	// sometimes halfway down so the edge is weak, sometimes anything.
	function automatic logic [7:0] pick_high(input int unsigned hl, input int unsigned ll);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return hl[7:0];
		if (pick < 88)
			return clip_strength(hl + c_delta + 1 + $urandom_range(0, 3));
		if (pick < 95)
			return clip_strength((hl + ll) / 2);
		return $urandom_range(0, 255);
	endfunction

	function automatic logic [7:0] pick_low(input int unsigned hl, input int unsigned ll);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			return ll[7:0];
		if (pick < 93)
			return clip_strength((hl + ll) / 2);
		return $urandom_range(0, 255);
	endfunction

	// One reception as the front end would report it: a long pause, a start
	// pulse mostly inside the sensitivity window, then alternating highs and
	// lows, and an ending that is usually a pause but may be a fault, a wrong
	// operation or nothing at all. Now and then a burst of noise comes first.
	task automatic run_reception();
		int unsigned win_lo;
		int unsigned win_hi;
		int unsigned start;
		int unsigned lo_lvl;
		int unsigned pairs;
		int unsigned ending;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 5))
				send_rand($urandom_range(0, 3), rand_duration(), $urandom_range(0, 255));
		end
		win_lo = c_sens;
		win_hi = c_sens + (c_sens >> 1);
		if (win_hi > 255)
			win_hi = 255;
		start = ($urandom_range(0, 9) != 0) ? $urandom_range(win_lo, win_hi)
			: $urandom_range(0, 255);
		lo_lvl = (start >= c_delta) ? $urandom_range(0, start - c_delta) : 0;
		pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 30);
		ending = $urandom_range(0, 99);
		send_rand(OP_LONG_PAUSE, rand_duration(), $urandom_range(0, 255));
		send_rand(OP_LOW_END, rand_duration(), start);
		for (int unsigned i = 0; i < pairs; i++) begin
			send_rand(OP_HIGH_END, rand_duration(), pick_low(start, lo_lvl));
			if (i + 1 < pairs)
				send_rand(OP_LOW_END, rand_duration(), pick_high(start, lo_lvl));
		end
		if (ending < 70) begin
			send_rand(OP_LONG_PAUSE, rand_duration(), $urandom_range(0, 255));
		end else if (ending < 80) begin
			send_rand(OP_FAULT, rand_duration(), $urandom_range(0, 255));
		end else if (ending < 88) begin
			// A high reported where a low is due.
			send_rand(OP_HIGH_END, rand_duration(), $urandom_range(0, 255));
		end else if (ending < 94) begin
			// A low ends normally, then anything but a high follows it.
			send_rand(OP_LOW_END, rand_duration(), pick_high(start, lo_lvl));
			send_rand($urandom_range(1, 3), rand_duration(), $urandom_range(0, 255));
		end
	endtask

	function automatic res_t make_end(input bit rv, input logic [11:0] idx,
			input logic [30:0] val, input logic [3:0] code, input logic [11:0] cnt,
			input logic [11:0] unrel, input logic [7:0] rh, input logic [7:0] rl);
		res_t r;
		r.record_valid = rv;
		r.record_index = idx;
		r.record_value = val;
		r.finished = 1'b1;
		r.end_code = code;
		r.recorded_count = cnt;
		r.unreliable_total = unrel;
		r.ref_high = rh;
		r.ref_low = rl;
		return r;
	endfunction

	function automatic void add_row(input logic [1:0] op, input logic [31:0] dur,
			input logic [7:0] ns, input bit known, input res_t exp);
		dir_row_t row;
		row.seg.operation = op;
		row.seg.duration = dur;
		row.seg.next_strength = ns;
		row.known = known;
		row.exp = exp;
		dir_rows.push_back(row);
	endfunction

	// The directed table runs on the reset register values: sensitivity 40,
	// delta 8, no practical length limit.
	function automatic void build_directed();
		// Anything but a pause is ignored while waiting for one.
		add_row(OP_LOW_END, 32'd0, 8'd0, 1'b0, '0);
		add_row(OP_LONG_PAUSE, 32'd0, 8'd255, 1'b0, '0);
		// Start pulse below the window.
		add_row(OP_LOW_END, 32'd10, 8'd30, 1'b1,
			make_end(1'b0, 12'd0, 31'd0, END_WEAK_START, 12'd0, 12'd0, 8'd30, 8'd0));
		add_row(OP_LONG_PAUSE, 32'd50, 8'd0, 1'b0, '0);
		// One above 1.5 times the sensitivity.
		add_row(OP_LOW_END, 32'd10, 8'd61, 1'b1,
			make_end(1'b0, 12'd0, 31'd0, END_STRONG_START, 12'd0, 12'd0, 8'd61, 8'd0));
		add_row(OP_LONG_PAUSE, 32'd50, 8'd0, 1'b0, '0);
		add_row(OP_LOW_END, 32'd10, 8'd50, 1'b0, '0);
		// A front-end fault on the very first high, at the longest duration.
		add_row(OP_FAULT, 32'hFFFF_FFFF, 8'd0, 1'b1,
			make_end(1'b1, 12'd1, 31'h7FFF_FFFF, END_FAULT, 12'd0, 12'd0, 8'd0, 8'd0));
		// A clean reception: full warm-up, a few main segments, then a pause.
		add_row(OP_LONG_PAUSE, 32'd800, 8'd0, 1'b0, '0);
		add_row(OP_LOW_END, 32'd10, 8'd50, 1'b0, '0);
		add_row(OP_HIGH_END, 32'd100, 8'd10, 1'b0, '0);
		add_row(OP_LOW_END, 32'd200, 8'd50, 1'b0, '0);
		add_row(OP_HIGH_END, 32'd0, 8'd10, 1'b0, '0);
		add_row(OP_LOW_END, 32'd1, 8'd50, 1'b0, '0);
		add_row(OP_HIGH_END, 32'd77, 8'd10, 1'b0, '0);
		add_row(OP_LOW_END, 32'd78, 8'd50, 1'b0, '0);
		add_row(OP_HIGH_END, 32'd301, 8'd10, 1'b0, '0);
		add_row(OP_LOW_END, 32'd302, 8'd50, 1'b0, '0);
		add_row(OP_HIGH_END, 32'd120, 8'd10, 1'b0, '0);
		add_row(OP_LOW_END, 32'd121, 8'd45, 1'b0, '0);
		// Weak falling edge on this high; one is tolerated after three good ones.
		add_row(OP_HIGH_END, 32'd99, 8'd40, 1'b0, '0);
		add_row(OP_LONG_PAUSE, 32'hFFFF_FFFF, 8'd0, 1'b0, '0);
		// Start exactly at the top of the window, a high, then a high where a low is due.
		add_row(OP_LONG_PAUSE, 32'd900, 8'd0, 1'b0, '0);
		add_row(OP_LOW_END, 32'd10, 8'd60, 1'b0, '0);
		add_row(OP_HIGH_END, 32'd42, 8'd0, 1'b0, '0);
		add_row(OP_HIGH_END, 32'd43, 8'd0, 1'b0, '0);
	endfunction

	initial begin
		in_valid = 1'b0;
		operation = '0;
		duration = '0;
		next_strength = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		c_sens = SENSITIVITY_RST;
		c_delta = DELTA_RST;
		c_max_length = MAX_LENGTH_RST;
		clear_reception();
		build_directed();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 31;
		rx_idle_pct = 83;
		foreach (dir_rows[k])
			send_segment(dir_rows[k].seg.operation, dir_rows[k].seg.duration,
				dir_rows[k].seg.next_strength, dir_rows[k].known, dir_rows[k].exp);
		drain_results();

		// Six random phases, two per idling pattern. Registers change only while
		// the block is drained, covering both extremes and a length limit below
		// its nominal range.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
			0: begin
				tx_idle_pct = 31;
				rx_idle_pct = 83;
			end
			1: begin
				tx_idle_pct = 83;
				rx_idle_pct = 31;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			endcase
			case (ph)
			0: write_regs(40, 8, 4095);
			1: write_regs(0, 0, 10);
			2: write_regs(255, 255, 4095);
			3: write_regs($urandom_range(20, 120), $urandom_range(1, 30), $urandom_range(0, 9));
			4: write_regs($urandom_range(10, 200), $urandom_range(0, 40), $urandom_range(10, 60));
			default: write_regs(100, 12, 30);
			endcase
			// With the receiver held off for a long stretch and the sender running
			// flat out, the output register fills and the input has to stall.
			if (ph == 4)
				hold_left = RX_HOLD_CYCLES;
			phase_results = 0;
			while (phase_results < RESULTS_PER_PHASE)
				run_reception();
			drain_results();
		end

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Far beyond the slowest legal run; reaching it means a beat went missing.
	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: ook_pulse_qualifier.f
+incdir+rtl
rtl/opq_pkg.sv
rtl/opq_in_stage.sv
rtl/opq_core.sv
rtl/opq_out_stage.sv
rtl/ook_pulse_qualifier.sv
tb/tb_top.sv
